// ----- rtl/tif_pkg.sv -----
// ----------------------------------------------------------------------------
// tif_pkg
// Shared types, telnet codes and a helper function for the telnet IAC filter.
// ----------------------------------------------------------------------------
package tif_pkg;

	// telnet command bytes
	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_SE   = 8'd240;

	// client bytes dropped outside raw mode
	localparam logic [7:0] CH_NUL  = 8'd0;
	localparam logic [7:0] CH_LF   = 8'd10;

	// binary transmission option
	localparam logic [7:0] OPT_BINARY = 8'd0;

	// parser states
	localparam logic [1:0] PS_DATA = 2'd0;
	localparam logic [1:0] PS_IAC  = 2'd1;
	localparam logic [1:0] PS_OPT  = 2'd2;
	localparam logic [1:0] PS_SUB  = 2'd3;

	// pending negotiation command, as command minus WILL
	localparam logic [1:0] PC_WILL = 2'd0;
	localparam logic [1:0] PC_WONT = 2'd1;
	localparam logic [1:0] PC_DO   = 2'd2;
	localparam logic [1:0] PC_DONT = 2'd3;

	// one classified input: up to three bytes in one direction
	typedef struct packed {
		logic [1:0] cnt;
		logic       to_client;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} cmd_t;

	// reply byte sent back for a negotiation command
	function automatic logic [7:0] reply_byte(input logic [1:0] pend);
		logic [7:0] r;
		case (pend)
			PC_WILL: r = TN_DO;
			PC_WONT: r = TN_DONT;
			PC_DO:   r = TN_WILL;
			PC_DONT: r = TN_WONT;
			default: r = TN_WONT;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/tif_front.sv -----
// ----------------------------------------------------------------------------
// tif_front
// Accepts bytes, runs the telnet parser and turns each byte into a command
// naming the bytes to send.
// ----------------------------------------------------------------------------
module tif_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               raw_mode,
	input  logic               accept,
	input  logic               action,
	input  logic [7:0]         data_byte,
	input  logic               door_active,
	output logic               cmd_push,
	output tif_pkg::cmd_t      cmd
);

	logic [1:0] parse_state_q;
	logic [1:0] pending_q;
	logic       binary_q;
	logic [1:0] parse_state_d;
	logic [1:0] pending_d;
	logic       binary_d;
	logic       want;
	logic [7:0] pend_diff;

	assign want      = ~pending_q[0];
	assign pend_diff = data_byte - tif_pkg::TN_WILL;

	// classify the byte and compute next parser state
	always_comb begin
		parse_state_d = parse_state_q;
		pending_d     = pending_q;
		binary_d      = binary_q;
		cmd.cnt       = 2'd0;
		cmd.to_client = 1'b0;
		cmd.b0        = data_byte;
		cmd.b1        = data_byte;
		cmd.b2        = tif_pkg::OPT_BINARY;
		if (action) begin
			cmd.to_client = 1'b1;
			cmd.cnt = (data_byte == tif_pkg::TN_IAC) ? 2'd2 : 2'd1;
		end else if ((!raw_mode && (data_byte == tif_pkg::CH_LF ||
				data_byte == tif_pkg::CH_NUL)) || !door_active) begin
			cmd.cnt = 2'd0;
		end else if (data_byte == tif_pkg::TN_IAC) begin
			if (parse_state_q == tif_pkg::PS_IAC) begin
				cmd.cnt       = 2'd1;
				parse_state_d = tif_pkg::PS_DATA;
			end else begin
				parse_state_d = tif_pkg::PS_IAC;
			end
		end else begin
			case (parse_state_q)
				tif_pkg::PS_IAC: begin
					if (data_byte >= tif_pkg::TN_WILL && data_byte <= tif_pkg::TN_DONT) begin
						pending_d     = pend_diff[1:0];
						parse_state_d = tif_pkg::PS_OPT;
					end else if (data_byte == tif_pkg::TN_SB) begin
						parse_state_d = tif_pkg::PS_SUB;
					end else begin
						parse_state_d = tif_pkg::PS_DATA;
					end
				end
				tif_pkg::PS_OPT: begin
					if (data_byte == tif_pkg::OPT_BINARY && binary_q != want) begin
						binary_d = want;
						cmd.cnt  = 2'd3;
						cmd.b0   = tif_pkg::TN_IAC;
						cmd.b1   = tif_pkg::reply_byte(pending_q);
					end
					parse_state_d = tif_pkg::PS_DATA;
				end
				tif_pkg::PS_SUB: begin
					if (data_byte == tif_pkg::TN_SE)
						parse_state_d = tif_pkg::PS_DATA;
				end
				default: begin
					cmd.cnt = 2'd1;
				end
			endcase
		end
	end

	assign cmd_push = accept && (cmd.cnt != 2'd0);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_state_q <= tif_pkg::PS_DATA;
			pending_q     <= tif_pkg::PC_WILL;
			binary_q      <= 1'b0;
		end else if (accept) begin
			parse_state_q <= parse_state_d;
			pending_q     <= pending_d;
			binary_q      <= binary_d;
		end
	end

endmodule

// ----- rtl/tif_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// tif_cmd_fifo
// Short command queue between the parser and the byte sender.
// ----------------------------------------------------------------------------
module tif_cmd_fifo #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  tif_pkg::cmd_t      wr_cmd,
	input  logic               rd_en,
	output tif_pkg::cmd_t      rd_cmd,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	tif_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	assign rd_cmd = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/tif_back.sv -----
// ----------------------------------------------------------------------------
// tif_back
// Takes commands from the queue and sends their bytes one per cycle while pop is held high.
// ----------------------------------------------------------------------------
module tif_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  tif_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic               pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               to_client,
	output logic               last
);

	tif_pkg::cmd_t cur_q;
	logic          cur_valid_q;
	logic [1:0]    idx_q;
	logic          taken;

	assign empty     = ~cur_valid_q;
	assign taken     = pop && cur_valid_q;
	assign last      = (idx_q == cur_q.cnt - 2'd1);
	assign to_client = cur_q.to_client;
	assign cmd_pop   = !cmd_empty && (!cur_valid_q || (taken && last));

	// byte select
	always_comb begin
		case (idx_q)
			2'd0:    out_byte = cur_q.b0;
			2'd1:    out_byte = cur_q.b1;
			default: out_byte = cur_q.b2;
		endcase
	end

	// current command payload
	always_ff @(posedge clk) begin
		if (cmd_pop)
			cur_q <= cmd;
	end

	// sender control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (cmd_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (taken) begin
			if (last) begin
				cur_valid_q <= 1'b0;
				idx_q       <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ----- rtl/telnet_iac_filter_unit.sv -----
// ----------------------------------------------------------------------------
// telnet_iac_filter_unit
// Telnet IAC filter: parser front end, command queue and byte sender.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle (push while full is low) and parses it
// in the same cycle; each byte becomes zero to three result bytes that leave
// through the result port at one byte per cycle (pop while empty is low).
// A byte that yields one result sustains one byte per cycle; bytes that yield
// two or three results are limited by the single output byte per cycle, and
// the QUEUE_DEPTH-entry command queue absorbs short bursts. Full rises only
// when that queue is filled. An accepted byte's command is written into the
// queue, then moves to the sender, and its first result can be popped only
// after that, at the earliest.
// raw_mode is written through cfg_we / cfg_wdata and should only be changed
// while the unit is idle.
module telnet_iac_filter_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       push,
	output logic       full,
	input  logic       action,
	input  logic [7:0] data_byte,
	input  logic       door_active,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       to_client,
	output logic       last
);

	logic          raw_mode_q;
	logic          accept;
	logic          cmd_push;
	logic          cmd_pop;
	logic          cmd_empty;
	tif_pkg::cmd_t front_cmd;
	tif_pkg::cmd_t queue_cmd;

	assign accept = push && !full;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			raw_mode_q <= 1'b0;
		else if (cfg_we)
			raw_mode_q <= cfg_wdata;
	end

	tif_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.raw_mode    (raw_mode_q),
		.accept      (accept),
		.action      (action),
		.data_byte   (data_byte),
		.door_active (door_active),
		.cmd_push    (cmd_push),
		.cmd         (front_cmd)
	);

	tif_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (front_cmd),
		.rd_en  (cmd_pop),
		.rd_cmd (queue_cmd),
		.full   (full),
		.empty  (cmd_empty)
	);

	tif_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (queue_cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.to_client (to_client),
		.last      (last)
	);

endmodule

// ----- verif/telnet_iac_filter_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telnet_iac_filter_unit_test
// Self-checking testbench for the telnet IAC filter. Bytes are pushed in both
// directions. A local model of the parser predicts the result bytes of every
// accepted byte, and each popped result is compared against the oldest
// prediction. Directed tests cover pass-through, drops, negotiation replies,
// subnegotiation skipping and raw mode. Random traffic then runs in phases
// with different sender idling, receiver stalling and raw mode settings.
// ----------------------------------------------------------------------------
module telnet_iac_filter_unit_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 30;

	// one predicted result byte
	typedef struct packed {
		logic [7:0] ob;
		logic       to_cl;
		logic       lst;
	} filter_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       action = 1'b0;
	logic [7:0] data_byte = 8'd0;
	logic       door_active = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       to_client;
	logic       last;

	// predictor state
	logic       raw_keep = 1'b0;
	logic [1:0] parse_q = tif_pkg::PS_DATA;
	logic [1:0] pend_q = tif_pkg::PC_WILL;
	logic       binary_q = 1'b0;

	filter_result_t expected_bytes[$];
	filter_result_t head;
	int errors = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;

	telnet_iac_filter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.action      (action),
		.data_byte   (data_byte),
		.door_active (door_active),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.to_client   (to_client),
		.last        (last)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	task automatic note_failure(input string what);
		if (errors < 10)
			$display("error at cycle %0d: %s", cycle_count, what);
		errors++;
	endtask

	// compare each popped transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				note_failure($sformatf("unexpected result byte %02h to_client %0b last %0b",
					out_byte, to_client, last));
			end else begin
				head = expected_bytes.pop_front();
				if (out_byte !== head.ob || to_client !== head.to_cl || last !== head.lst)
					note_failure($sformatf(
						"expected byte %02h to_client %0b last %0b, got %02h %0b %0b",
						head.ob, head.to_cl, head.lst, out_byte, to_client, last));
			end
		end
	end

	// parser model: queues the result bytes caused by one accepted byte
	function automatic void filter_byte(input logic act, input logic [7:0] b,
			input logic active);
		logic [7:0] outs [3];
		int n;
		int i;
		logic want;
		logic [7:0] rep;
		n = 0;
		if (act) begin
			// door to client, IAC doubled
			if (b == tif_pkg::TN_IAC) begin
				outs[n] = b;
				n++;
			end
			outs[n] = b;
			n++;
		end else if ((!raw_keep && (b == tif_pkg::CH_NUL || b == tif_pkg::CH_LF)) ||
				!active) begin
			n = 0;
		end else if (b == tif_pkg::TN_IAC) begin
			if (parse_q == tif_pkg::PS_IAC) begin
				outs[0] = tif_pkg::TN_IAC;
				n = 1;
				parse_q = tif_pkg::PS_DATA;
			end else begin
				parse_q = tif_pkg::PS_IAC;
			end
		end else begin
			case (parse_q)
				tif_pkg::PS_IAC: begin
					if (b >= tif_pkg::TN_WILL && b <= tif_pkg::TN_DONT) begin
						pend_q = 2'(b - tif_pkg::TN_WILL);
						parse_q = tif_pkg::PS_OPT;
					end else if (b == tif_pkg::TN_SB) begin
						parse_q = tif_pkg::PS_SUB;
					end else begin
						parse_q = tif_pkg::PS_DATA;
					end
				end
				tif_pkg::PS_OPT: begin
					if (b == tif_pkg::OPT_BINARY) begin
						want = (pend_q == tif_pkg::PC_WILL || pend_q == tif_pkg::PC_DO);
						case (pend_q)
							tif_pkg::PC_WILL: rep = tif_pkg::TN_DO;
							tif_pkg::PC_WONT: rep = tif_pkg::TN_DONT;
							tif_pkg::PC_DO:   rep = tif_pkg::TN_WILL;
							default:          rep = tif_pkg::TN_WONT;
						endcase
						if (binary_q != want) begin
							binary_q = want;
							outs[0] = tif_pkg::TN_IAC;
							outs[1] = rep;
							outs[2] = tif_pkg::OPT_BINARY;
							n = 3;
						end
					end
					parse_q = tif_pkg::PS_DATA;
				end
				tif_pkg::PS_SUB: begin
					if (b == tif_pkg::TN_SE)
						parse_q = tif_pkg::PS_DATA;
				end
				default: begin
					outs[0] = b;
					n = 1;
				end
			endcase
		end
		for (i = 0; i < n; i++)
			expected_bytes.push_back('{ob: outs[i], to_cl: act, lst: (i == n - 1)});
	endfunction

	// push one byte; returns at the falling edge after the transaction
	task automatic send_byte(input logic act, input logic [7:0] b, input logic active);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		action = act;
		data_byte = b;
		door_active = active;
		@(posedge clk);
		while (full)
			@(posedge clk);
		filter_byte(act, b, active);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_client(input logic [7:0] b);
		send_byte(1'b0, b, 1'b1);
	endtask

	// stop sending and let every expected result come out
	task automatic wait_drain();
		push = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_raw_mode(input logic v);
		wait_drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		raw_keep = v;
	endtask

	// pass-through and dropped bytes
	task automatic test_passthrough();
		set_raw_mode(1'b0);
		send_byte(1'b1, 8'h41, 1'b1);
		send_byte(1'b1, tif_pkg::TN_IAC, 1'b0);
		send_client(8'h7e);
		send_client(tif_pkg::CH_NUL);
		send_client(tif_pkg::CH_LF);
		send_byte(1'b0, 8'h42, 1'b0);
	endtask

	// option negotiation outside raw mode: the NUL option byte is dropped, so no reply is sent
	task automatic test_negotiation();
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_WILL);
		send_client(tif_pkg::OPT_BINARY);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_DONT);
		send_client(tif_pkg::OPT_BINARY);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_DO);
		send_client(tif_pkg::OPT_BINARY);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_WONT);
		send_client(tif_pkg::OPT_BINARY);
		// other option is consumed silently
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_WILL);
		send_client(8'd3);
	endtask

	// escaped IAC, unknown command, subnegotiation ends
	task automatic test_subnegotiation();
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_IAC);
		send_client(8'h31);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_SB);
		send_client(8'h18);
		send_client(tif_pkg::TN_SE);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_SB);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_SE);
	endtask

	// raw mode keeps NUL and newline, NUL can serve as the option
	task automatic test_raw_mode();
		set_raw_mode(1'b1);
		send_client(tif_pkg::CH_NUL);
		send_client(tif_pkg::CH_LF);
		send_client(tif_pkg::TN_IAC);
		send_client(tif_pkg::TN_WILL);
		send_client(tif_pkg::OPT_BINARY);
		send_byte(1'b1, 8'hff, 1'b1);
	endtask

	// one random sequence, mostly well formed
	task automatic random_sequence();
		int kind;
		int k;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: send_byte(1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
			3: begin
				if ($urandom_range(0, 3) == 0)
					send_byte(1'b1, tif_pkg::TN_IAC, 1'($urandom_range(0, 1)));
				else
					send_byte(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			4: begin
				send_client(tif_pkg::TN_IAC);
				send_client(tif_pkg::TN_IAC);
			end
			5, 6: begin
				send_client(tif_pkg::TN_IAC);
				send_client(8'(tif_pkg::TN_WILL + $urandom_range(0, 3)));
				if ($urandom_range(0, 3) != 0)
					send_client(tif_pkg::OPT_BINARY);
				else
					send_client(8'($urandom_range(0, 255)));
			end
			7: begin
				send_client(tif_pkg::TN_IAC);
				send_client(tif_pkg::TN_SB);
				k = $urandom_range(0, 3);
				repeat (k) send_client(8'($urandom_range(0, 254)));
				if ($urandom_range(0, 1))
					send_client(tif_pkg::TN_IAC);
				send_client(tif_pkg::TN_SE);
			end
			8: begin
				send_client(tif_pkg::TN_IAC);
				send_client(8'($urandom_range(0, 255)));
			end
			default: send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		endcase
	endtask

	// random traffic under one idling profile
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input logic raw, input logic hold_off);
		int start;
		set_raw_mode(raw);
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			random_sequence();
			// pause the sender until the result side is empty
			if (hold_off && items_sent - start >= RANDOM_ITEMS / 2) begin
				wait_drain();
				hold_off = 1'b0;
			end
		end
	endtask

	// test sequence
	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_passthrough();
		test_negotiation();
		test_subnegotiation();
		test_raw_mode();
		test_random_traffic(0, 0, 1'b0, 1'b0);
		test_random_traffic(52, 0, 1'b1, 1'b1);
		test_random_traffic(0, 52, 1'b0, 1'b0);
		test_random_traffic(34, 34, 1'b1, 1'b0);
		wait_drain();
		if (expected_bytes.size() != 0)
			note_failure($sformatf("%0d result bytes never arrived", expected_bytes.size()));
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
